// File: rtl/core/lnv_pkg.sv
// ---------------------------------------------------------------------------
// Layer normalisation package
// Shared types, constants and state codes for the layer normalisation block.
// ---------------------------------------------------------------------------
package lnv_pkg;

    localparam int MAX_LEN   = 64;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int COUNT_W   = $clog2(MAX_LEN + 1);
    localparam int SUM_W     = 22;
    localparam int DIFF_W    = 17;
    localparam int SQSUM_W   = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_ENABLE = 2'd2;

    // Operations of the shared divide / square root unit.
    typedef enum logic [1:0] {
        OP_DIV_SIGNED,
        OP_DIV_UNSIGNED,
        OP_SQRT
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_VAR_RD,
        ST_VAR_ACC,
        ST_VAR_DIV,
        ST_VAR_WAIT,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_OUT_RD,
        ST_OUT_DIV,
        ST_OUT_WAIT,
        ST_OUT_SCALE,
        ST_OUT_EMIT
    } state_t;

    typedef struct packed {
        logic                start;
        alu_op_t             op;
        logic signed [47:0]  num;
        logic        [47:0]  den;
    } alu_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic signed [47:0]  result;
    } alu_rsp_t;

endpackage

// File: rtl/core/lnv_stream_if.sv
// ---------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for the input and result items.
// ---------------------------------------------------------------------------
interface lnv_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic signed [15:0] scale;
    logic signed [15:0] shift;
    logic               final_req;

    modport source (output valid, sample, scale, shift, final_req, input ready);
    modport sink   (input valid, sample, scale, shift, final_req, output ready);
endinterface

interface lnv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normalized;
    logic               clipped;
    logic               end_of_vector;

    modport source (output valid, normalized, clipped, end_of_vector, input ready);
    modport sink   (input valid, normalized, clipped, end_of_vector, output ready);
endinterface

// File: rtl/core/lnv_alu.sv
// ---------------------------------------------------------------------------
// Shared divide and square root unit
// Restoring division (one quotient bit per cycle) and a digit-by-digit
// integer square root (one result bit per cycle).
// ---------------------------------------------------------------------------
module lnv_alu
    import lnv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic        [5:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               sqrt_reg, sqrt_next;
    logic               neg_reg, neg_next;
    logic        [47:0] quo_reg, quo_next;
    logic        [48:0] rem_reg, rem_next;
    logic        [47:0] den_reg, den_next;
    logic        [47:0] root_reg, root_next;
    logic        [47:0] mag;
    logic        [48:0] trial;
    logic        [49:0] strial;
    logic        [49:0] srem;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        root_next = root_reg;
        mag       = (req.op == OP_DIV_SIGNED && req.num < 0) ? 48'(-req.num)
                                                             : 48'(req.num);
        trial     = {rem_reg[47:0], quo_reg[47]};
        srem      = {rem_reg[47:0], quo_reg[47:46]};
        strial    = {root_reg, 2'b01};
        if (req.start)
        begin
            busy_next = 1'b1;
            sqrt_next = (req.op == OP_SQRT);
            neg_next  = (req.op == OP_DIV_SIGNED) && (req.num < 0);
            quo_next  = mag;
            rem_next  = '0;
            den_next  = req.den;
            root_next = '0;
            cnt_next  = (req.op == OP_SQRT) ? 6'd24 : 6'd48;
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                if (srem >= strial)
                begin
                    rem_next  = 49'(srem - strial);
                    root_next = {root_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next  = 49'(srem);
                    root_next = {root_reg[46:0], 1'b0};
                end
                quo_next = {quo_reg[45:0], 2'b00};
            end
            else
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    quo_next = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[46:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        root_reg <= root_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = sqrt_reg ? $signed(root_reg)
                      : (neg_reg ? -$signed(quo_reg) : $signed(quo_reg));

endmodule

// File: rtl/core/lnv_ctrl.sv
// ---------------------------------------------------------------------------
// Layer normalisation sequencer
// Loads the vector into the stores, then runs the mean, variance, square
// root and output passes on the shared unit.
// ---------------------------------------------------------------------------
module lnv_ctrl
    import lnv_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    lnv_in_if.sink          in_ch,
    lnv_out_if.source       out_ch,
    input  logic [15:0]     epsilon,
    input  logic            scale_en,
    input  logic            shift_en,
    output alu_req_t        alu_req,
    input  alu_rsp_t        alu_rsp
);

    logic [15:0] sample_mem [MAX_LEN];
    logic [15:0] scale_mem  [MAX_LEN];
    logic [15:0] shift_mem  [MAX_LEN];

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]   rd_addr;
    logic signed [15:0]  rd_sample, rd_scale, rd_shift;
    logic signed [15:0]  mean_reg, mean_next;
    logic [SQSUM_W-1:0]  sq_reg, sq_next;
    logic [31:0]         var_reg, var_next;
    logic [15:0]         sd_reg, sd_next;
    logic signed [DIFF_W-1:0] diff;
    logic [33:0]         diff_sq;
    logic signed [47:0]  v_reg, v_next;
    logic signed [25:0]  v_short;
    logic signed [41:0]  prod;
    logic signed [41:0]  prod_q;
    logic signed [47:0]  vs;
    logic signed [15:0]  res_reg, res_next;
    logic                clip_reg, clip_next;
    logic                last_reg, last_next;
    logic                store_we;
    logic                accept;

    assign accept   = in_ch.valid && in_ch.ready;
    assign store_we = accept && (count_reg < COUNT_W'(MAX_LEN));

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            sample_mem[count_reg[ADDR_W-1:0]] <= in_ch.sample;
            scale_mem[count_reg[ADDR_W-1:0]]  <= in_ch.scale;
            shift_mem[count_reg[ADDR_W-1:0]]  <= in_ch.shift;
        end
        rd_sample <= sample_mem[rd_addr];
        rd_scale  <= scale_mem[rd_addr];
        rd_shift  <= shift_mem[rd_addr];
    end

    // The quotient of a Q8.8 deviation by a standard deviation of at least one
    // fits in 26 signed bits, so the scale product needs only 26 by 16 bits.
    assign rd_addr = idx_reg;
    assign diff    = DIFF_W'(rd_sample) - DIFF_W'(mean_reg);
    assign diff_sq = 34'(diff * diff);
    assign v_short = 26'(v_reg);
    assign prod    = 42'(v_short) * 42'(rd_scale);
    assign prod_q  = (prod < 0) ? -((-prod) >>> 8) : (prod >>> 8);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        idx_next   = idx_reg;
        mean_next  = mean_reg;
        sq_next    = sq_reg;
        var_next   = var_reg;
        sd_next    = sd_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        clip_next  = clip_reg;
        last_next  = last_reg;
        vs         = v_reg;
        alu_req.start = 1'b0;
        alu_req.op    = OP_DIV_SIGNED;
        alu_req.num   = '0;
        alu_req.den   = 48'(count_reg);
        in_ch.ready   = (state_reg == ST_LOAD);
        out_ch.valid  = (state_reg == ST_OUT_EMIT);
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (store_we)
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SUM_W'(in_ch.sample);
                    end
                    if (in_ch.final_req)
                        state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                alu_req.start = 1'b1;
                alu_req.num   = 48'(sum_reg);
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    mean_next  = 16'(alu_rsp.result);
                    idx_next   = '0;
                    sq_next    = '0;
                    state_next = ST_VAR_RD;
                end
            end
            ST_VAR_RD:
                state_next = ST_VAR_ACC;
            ST_VAR_ACC:
            begin
                sq_next = sq_reg + SQSUM_W'(diff_sq);
                if (COUNT_W'(idx_reg) + 1'b1 == count_reg)
                    state_next = ST_VAR_DIV;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_VAR_RD;
                end
            end
            ST_VAR_DIV:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_DIV_UNSIGNED;
                alu_req.num   = 48'(sq_reg);
                state_next    = ST_VAR_WAIT;
            end
            ST_VAR_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    var_next   = 32'(alu_rsp.result);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_SQRT;
                alu_req.num   = 48'(var_reg) + 48'(epsilon);
                state_next    = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    sd_next    = (alu_rsp.result == 0) ? 16'd1 : 16'(alu_rsp.result);
                    idx_next   = '0;
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD:
                state_next = ST_OUT_DIV;
            ST_OUT_DIV:
            begin
                alu_req.start = 1'b1;
                alu_req.num   = 48'(diff) <<< 8;
                alu_req.den   = 48'(sd_reg);
                state_next    = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    v_next     = alu_rsp.result;
                    state_next = ST_OUT_SCALE;
                end
            end
            ST_OUT_SCALE:
            begin
                if (scale_en)
                    vs = 48'(prod_q);
                if (shift_en)
                    vs = vs + 48'(rd_shift);
                clip_next = 1'b0;
                if (vs > 48'sd32767)
                begin
                    res_next  = 16'sh7fff;
                    clip_next = 1'b1;
                end
                else if (vs < -48'sd32768)
                begin
                    res_next  = 16'sh8000;
                    clip_next = 1'b1;
                end
                else
                    res_next = 16'(vs);
                last_next  = (COUNT_W'(idx_reg) + 1'b1 == count_reg);
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                if (out_ch.ready)
                begin
                    if (last_reg)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        sq_reg   <= sq_next;
        var_reg  <= var_next;
        sd_reg   <= sd_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        clip_reg <= clip_next;
        last_reg <= last_next;
    end

    assign out_ch.normalized    = res_reg;
    assign out_ch.clipped       = clip_reg;
    assign out_ch.end_of_vector = last_reg;

endmodule

// File: rtl/core/layer_norm_vector.sv
// ---------------------------------------------------------------------------
// Layer normalisation of one vector
// Loads up to MAX_LEN Q8.8 elements, then emits each normalised element,
// optionally scaled and shifted, saturated to Q8.8.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_ch     sink       sample, scale, shift, final_req
//  out_ch    source     normalized, clipped, end_of_vector
//  cfg       write      cfg_we, cfg_index, cfg_data
//
// Loading accepts one item per cycle. After the last mark come the mean
// division, the variance pass, the variance division and the square
// root, each but the pass on the shared bit-serial unit; each result
// then needs its own division there. The block accepts no input item
// until the last result of the vector has been taken. A stalled result
// simply holds; reset needs no clearing pass.
module layer_norm_vector
    import lnv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lnv_in_if.sink               in_ch,
    lnv_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic [15:0] epsilon_reg;
    logic        scale_en_reg;
    logic        shift_en_reg;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    // Configuration registers; only bit 0 of the enables counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg  <= 16'd1;
            scale_en_reg <= 1'b0;
            shift_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EPSILON:      epsilon_reg  <= cfg_data;
                REG_SCALE_ENABLE: scale_en_reg <= cfg_data[0];
                REG_SHIFT_ENABLE: shift_en_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    lnv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .epsilon  (epsilon_reg),
        .scale_en (scale_en_reg),
        .shift_en (shift_en_reg),
        .alu_req  (alu_req),
        .alu_rsp  (alu_rsp)
    );

    lnv_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

endmodule

// File: rtl/core/lnv_checker.sv
// ---------------------------------------------------------------------------
// Port checker
// Concurrent checks on the ports of the layer normalisation block.
// ---------------------------------------------------------------------------
module lnv_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_eov
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken while results pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");

    a_eov_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_eov |=> in_ready)
        else $error("not loading after end of vector");

endmodule

bind layer_norm_vector lnv_checker u_lnv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_eov   (out_ch.end_of_vector)
);
